@@ src/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and types for the sorted list table.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // broadcast from the control stage to every cell
  typedef struct packed {
    logic                    insert_en;
    logic                    remove_en;
    logic signed [VAL_W-1:0] value;
  } slt_ctrl_t;

  // compare flags of one cell against the broadcast value
  typedef struct packed {
    logic gt;
    logic ge;
    logic eq;
  } slt_stat_t;

endpackage

`default_nettype wire

@@ src/slt_cell.sv @@
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the sorted chain: compares its entry with the broadcast value
// and shifts toward or away from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cell (
  input  wire logic                             clk,
  input  wire slt_pkg::slt_ctrl_t               ctrl,
  input  wire logic                             cell_valid,
  input  wire logic                             left_gt,
  input  wire logic signed [slt_pkg::VAL_W-1:0] left_entry,
  input  wire logic signed [slt_pkg::VAL_W-1:0] right_entry,
  output logic signed [slt_pkg::VAL_W-1:0]      entry,
  output slt_pkg::slt_stat_t                    stat
);
  import slt_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    le;

  always_comb begin
    stat.gt = cell_valid && (entry_r > ctrl.value);
    stat.ge = cell_valid && (entry_r >= ctrl.value);
    stat.eq = cell_valid && (entry_r == ctrl.value);
    le      = cell_valid && !(entry_r > ctrl.value);
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert_en) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (!le) begin
        entry_nxt = ctrl.value;
      end
    end else if (ctrl.remove_en && stat.ge) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

@@ src/sorted_list_table.sv @@
// ----------------------------------------------------------------------------
// sorted_list_table
// Bounded ascending multiset of signed 32-bit values held in a row of
// compare-and-shift cells; insert, remove first match, search.
// ----------------------------------------------------------------------------
// One request is taken every cycle; busy stays low. A request is registered
// on acceptance, all cells compare it with their entries in parallel in the
// next cycle and shift in that same cycle, and the result is registered once
// more before it appears on the out_ ports with out_strobe. The receiver
// cannot stall, so out_strobe is a one-cycle pulse per request. The next
// request is evaluated against the table as left by the one before it.
`default_nettype none

module sorted_list_table (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_req_type,
  input  wire logic signed [slt_pkg::VAL_W-1:0] in_value,
  output logic                                  out_strobe,
  output logic [1:0]                            out_status,
  output logic [4:0]                            out_entry_count
);
  import slt_pkg::*;

  logic                    req_valid_r;
  logic [1:0]              req_type_r;
  logic signed [VAL_W-1:0] value_r;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;

  logic                    out_strobe_r;
  logic [1:0]              out_status_r;
  logic [4:0]              out_entry_count_r;
  logic [1:0]              status_nxt;

  slt_ctrl_t               ctrl;
  slt_stat_t               stat [CAPACITY];
  logic signed [VAL_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]     eq_vec;
  logic                    found;
  logic                    full;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_type_r <= in_req_type;
      value_r    <= in_value;
    end
  end

  // cell row
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                    lgt;
      logic signed [VAL_W-1:0] lent;
      logic signed [VAL_W-1:0] rent;
      if (gi == 0) begin : g_first
        assign lgt  = 1'b0;
        assign lent = entry[gi];
      end else begin : g_mid
        assign lgt  = stat[gi-1].gt;
        assign lent = entry[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign rent = entry[gi];
      end else begin : g_notlast
        assign rent = entry[gi+1];
      end
      assign eq_vec[gi] = stat[gi].eq;

      slt_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .cell_valid  (CNT_W'(gi) < count_r),
        .left_gt     (lgt),
        .left_entry  (lent),
        .right_entry (rent),
        .entry       (entry[gi]),
        .stat        (stat[gi])
      );
    end
  endgenerate

  assign found = |eq_vec;
  assign full  = (count_r >= CNT_W'(CAPACITY));

  always_comb begin
    ctrl.value     = value_r;
    ctrl.insert_en = 1'b0;
    ctrl.remove_en = 1'b0;
    count_nxt      = count_r;
    status_nxt     = ST_MISSING;
    if (req_valid_r) begin
      unique case (req_type_r)
        REQ_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.insert_en = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            status_nxt     = ST_OK;
          end
        end
        REQ_REMOVE: begin
          if (found) begin
            ctrl.remove_en = 1'b1;
            count_nxt      = count_r - CNT_W'(1);
            status_nxt     = ST_OK;
          end
        end
        REQ_SEARCH: begin
          if (found) begin
            status_nxt = ST_OK;
          end
        end
        default: begin
          status_nxt = ST_MISSING;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r      <= status_nxt;
    out_entry_count_r <= 5'(count_nxt);
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r |=> out_strobe_r)
    else $error("request without result");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r == ST_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && req_type_r == REQ_INSERT && !full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.insert_en && ctrl.remove_en))
    else $error("insert and remove at once");

endmodule

`default_nettype wire

@@ sim/sorted_list_table_test.sv @@
// ----------------------------------------------------------------------------
// sorted_list_table_test
// Drives insert, remove, search and unused requests into the sorted list
// table with random gaps. A local copy of the table predicts the status and
// count of every request, and each out_strobe result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam logic [1:0]             REQ_UNUSED     = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN       = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX       = 32'sh7fff_ffff;
  localparam int                     WATCHDOG_LIMIT = 1000;
  localparam int                     SETTLE_CYCLES  = 8;

  typedef struct {
    logic [1:0] status;
    logic [4:0] entry_count;
  } table_reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic [1:0]              in_req_type = REQ_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    busy;
  logic                    out_strobe;
  logic [1:0]              out_status;
  logic [4:0]              out_entry_count;

  logic signed [VAL_W-1:0] held_vals[$];
  table_reply_t            reply_queue[$];
  int                      mismatch_count = 0;
  int                      idle_cycles = 0;
  bit                      steady_flow = 1'b0;

  always #6 clk = ~clk;

  sorted_list_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic table_reply_t apply_request(input logic [1:0] kind,
                                                 input logic signed [VAL_W-1:0] val);
    table_reply_t reply;
    int           pos;
    pos = 0;
    reply.status = ST_MISSING;
    case (kind)
      REQ_INSERT: begin
        if (held_vals.size() >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          while (pos < held_vals.size() && held_vals[pos] <= val) pos++;
          held_vals.insert(pos, val);
          reply.status = ST_OK;
        end
      end
      REQ_REMOVE: begin
        while (pos < held_vals.size() && held_vals[pos] != val) pos++;
        if (pos < held_vals.size()) begin
          held_vals.delete(pos);
          reply.status = ST_OK;
        end
      end
      REQ_SEARCH: begin
        while (pos < held_vals.size() && held_vals[pos] != val) pos++;
        if (pos < held_vals.size()) reply.status = ST_OK;
      end
      default: ;
    endcase
    reply.entry_count = 5'(held_vals.size());
    return reply;
  endfunction

  // accepted items feed the prediction, results are checked against it
  always @(posedge clk) begin
    table_reply_t exp_reply;
    if (rst_n) begin
      if (start && busy === 1'b0) begin
        reply_queue.push_back(apply_request(in_req_type, in_value));
      end
      if (out_strobe === 1'b1) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("result with no item waiting");
        end else begin
          exp_reply = reply_queue.pop_front();
          if (out_status !== exp_reply.status) begin
            report_mismatch($sformatf("status exp %0d got %0d",
                                      exp_reply.status, out_status));
          end
          if (out_entry_count !== exp_reply.entry_count) begin
            report_mismatch($sformatf("entry_count exp %0d got %0d",
                                      exp_reply.entry_count, out_entry_count));
          end
        end
      end
      if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: watchdog expired", $realtime);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic signed [VAL_W-1:0] val);
    int gap;
    start       <= 1'b1;
    in_req_type <= kind;
    in_value    <= val;
    do @(posedge clk); while (busy !== 1'b0);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    @(posedge clk);
    while (reply_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 8) - 4;
    if (r < 65 && held_vals.size() > 0) return held_vals[$urandom_range(0, held_vals.size() - 1)];
    if (r < 72) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_kind(input int insert_pct);
    if ($urandom_range(0, 99) < 3) return REQ_UNUSED;
    if ($urandom_range(0, 99) < insert_pct) return REQ_INSERT;
    return ($urandom_range(0, 99) < 60) ? REQ_REMOVE : REQ_SEARCH;
  endfunction

  task automatic test_empty_table();
    send_request(REQ_SEARCH, 32'sd0);
    send_request(REQ_REMOVE, VAL_MAX);
    send_request(REQ_UNUSED, VAL_MIN);
  endtask

  task automatic test_single_entry();
    send_request(REQ_INSERT, 32'sd5);
    send_request(REQ_SEARCH, 32'sd5);
    send_request(REQ_SEARCH, -32'sd5);
    send_request(REQ_REMOVE, 32'sd5);
  endtask

  task automatic test_extremes_and_full();
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, -32'sd1);
    send_request(REQ_SEARCH, VAL_MIN);
    send_request(REQ_REMOVE, VAL_MAX);
    repeat (CAPACITY - 3) send_request(REQ_INSERT, $urandom());
    send_request(REQ_INSERT, 32'sd0);
  endtask

  task automatic test_random_traffic(input int n_items, input int insert_pct);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      send_request(pick_kind(insert_pct), pick_value());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_single_entry();
    test_extremes_and_full();
    test_random_traffic(300, 75);
    wait_for_replies();
    test_random_traffic(300, 20);
    test_random_traffic(420, 50);
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reply_queue.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", reply_queue.size()));
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/slt_pkg.sv
src/slt_cell.sv
src/sorted_list_table.sv
sim/sorted_list_table_test.sv
